// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int unsigned POS_W = 11;

  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;
  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7e;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic             cell_written;
    logic [POS_W-1:0] cell_address;
    logic [15:0]      cell_value;
    logic             scrolled;
    logic             last_of_write;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL
  } tcw_state_e;

endpackage

// ----- design/tcw_ifs.sv -----
// Valid/ready channel interfaces for the character input and the result output.
interface tcw_in_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/text_console_char_writer.sv -----
// Text console character writer: screen memory, cursor and scroll sequencer.
//
// The block holds a COLUMNS x ROWS screen of 16-bit cells in one synchronous
// memory with a single write port and a cursor kept as line start plus column.
// A character is taken on an input handshake and its result is registered in the
// output register, or in the holding slot behind it while that register is full; the
// two-entry output queue lets the next character enter while a result still waits.
// When a character pushes the cursor past the last row, the scroll sequencer copies
// every row up by one and clears the last row, one cell per cycle through the
// memory's read and write ports, and the input stalls until it is done. After reset
// the memory is cleared one cell per cycle before the first character is taken.
// All other characters are taken back to back while the output queue has room.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STEP = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tcw_in_if.sink          in_i,
  tcw_out_if.source       out_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned CSW   = CW + 2;

  localparam logic [AW:0]    CELLS_X    = (AW+1)'(CELLS);
  localparam logic [AW:0]    COLS_X     = (AW+1)'(COLUMNS);
  localparam logic [AW:0]    COLS2_X    = (AW+1)'(2 * COLUMNS);
  localparam logic [AW:0]    SCROLL_END = (AW+1)'(CELLS + COLUMNS);
  localparam logic [AW-1:0]  LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_LINE  = AW'(CELLS - COLUMNS);
  localparam logic [CSW-1:0] COLS_C     = CSW'(COLUMNS);
  localparam logic [CSW-1:0] COLS2_C    = CSW'(2 * COLUMNS);
  localparam logic [CSW-1:0] TAB_C      = CSW'(TAB_STEP);
  localparam logic [CW-1:0]  LAST_COL   = CW'(COLUMNS - 1);

  tcw_state_e state_q, state_d;

  logic [15:0]   cells [CELLS];
  logic [15:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [AW-1:0] clr_q;
  logic [AW:0]   src_q;
  logic          pipe_vld_q;
  logic [AW-1:0] pipe_dst_q;
  logic          pipe_zero_q;

  logic [AW-1:0] cur_q, line_q;
  logic [CW-1:0] col_q;

  logic      out_vld_q, hold_vld_q;
  out_item_t out_q, hold_q;

  logic accept, out_take;

  // Next cursor for the offered character.
  logic           is_print, is_nl, is_tab;
  logic [CSW-1:0] col_sum, col_wrap;
  logic [AW:0]    line_adv, line_scr;
  logic           scroll_n, sat_n;
  logic [AW-1:0]  line_n, cur_n;
  logic [CW-1:0]  col_n;
  logic [15:0]    value_n;
  out_item_t      res;

  assign is_print = (in_i.data.char_code >= CHAR_PRINT_LO) &&
                    (in_i.data.char_code <= CHAR_PRINT_HI);
  assign is_nl    = (in_i.data.char_code == CHAR_NEWLINE);
  assign is_tab   = (in_i.data.char_code == CHAR_TAB);
  assign value_n  = {in_i.data.attribute, in_i.data.char_code};

  always_comb begin
    col_sum = CSW'(col_q);
    if (is_print) begin
      col_sum = CSW'(col_q) + CSW'(1);
    end else if (is_nl) begin
      // A newline is a jump to column COLUMNS, which wraps to the next line.
      col_sum = COLS_C;
    end else if (is_tab) begin
      col_sum = CSW'(col_q) + TAB_C;
    end

    if (col_sum >= COLS2_C) begin
      col_wrap = col_sum - COLS2_C;
      line_adv = (AW+1)'(line_q) + COLS2_X;
    end else if (col_sum >= COLS_C) begin
      col_wrap = col_sum - COLS_C;
      line_adv = (AW+1)'(line_q) + COLS_X;
    end else begin
      col_wrap = col_sum;
      line_adv = (AW+1)'(line_q);
    end

    scroll_n = (line_adv >= CELLS_X);
    line_scr = scroll_n ? (line_adv - COLS_X) : line_adv;
    // Only a tab wider than a row can leave the cursor off screen after a scroll.
    sat_n    = (line_scr >= CELLS_X);
    line_n   = sat_n ? LAST_LINE : line_scr[AW-1:0];
    col_n    = sat_n ? LAST_COL : col_wrap[CW-1:0];
    cur_n    = line_n + AW'(col_n);
  end

  always_comb begin
    res                 = '0;
    res.cursor_position = POS_W'((AW+POS_W)'(cur_n));
    res.cell_written    = is_print;
    res.cell_address    = is_print ? POS_W'((AW+POS_W)'(cur_q)) : '0;
    res.cell_value      = is_print ? value_n : '0;
    res.scrolled        = scroll_n;
    res.last_of_write   = in_i.data.end_of_buffer;
  end

  assign accept   = in_i.valid && in_i.ready;
  assign out_take = out_vld_q && out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_CELL) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && scroll_n) state_d = ST_SCROLL;
      end
      ST_SCROLL: begin
        if (src_q == SCROLL_END) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur_q;
    mem_wdata  = value_n;
    mem_raddr  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_i.ready = !hold_vld_q;
        mem_we     = accept && is_print;
      end
      ST_SCROLL: begin
        mem_we    = pipe_vld_q;
        mem_waddr = pipe_dst_q;
        mem_wdata = pipe_zero_q ? '0 : rdata_q;
        mem_raddr = (src_q < CELLS_X) ? src_q[AW-1:0] : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cells[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= cells[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      src_q      <= '0;
      pipe_vld_q <= 1'b0;
      cur_q      <= '0;
      line_q     <= '0;
      col_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      // Each copy reads the cell one row below into the read register and writes it from there.
      if (state_q == ST_SCROLL && src_q != SCROLL_END) begin
        src_q      <= src_q + (AW+1)'(1);
        pipe_vld_q <= 1'b1;
      end else begin
        src_q      <= COLS_X;
        pipe_vld_q <= 1'b0;
      end
      if (accept) begin
        cur_q  <= cur_n;
        line_q <= line_n;
        col_q  <= col_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_dst_q  <= AW'(src_q - COLS_X);
    pipe_zero_q <= (src_q >= CELLS_X);
  end

  // Output register with one holding slot behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      if (out_take) begin
        out_vld_q  <= hold_vld_q || accept;
        hold_vld_q <= hold_vld_q && accept;
      end else if (!out_vld_q) begin
        out_vld_q <= accept;
      end else if (accept) begin
        hold_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= hold_vld_q ? hold_q : res;
      if (accept) hold_q <= res;
    end else if (!out_vld_q) begin
      if (accept) out_q <= res;
    end else if (accept) begin
      hold_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  a_hold_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> out_vld_q)
    else $error("holding slot filled while output register is empty");

  a_cursor_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q == line_q + AW'(col_q)) && ((AW+1)'(cur_q) < CELLS_X))
    else $error("cursor does not match line start plus column");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input ready while clearing or scrolling");

  a_scroll_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && scroll_n) |=> (state_q == ST_SCROLL))
    else $error("scrolled character did not start the scroll sequencer");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && pipe_vld_q) |-> $past(state_q == ST_SCROLL))
    else $error("scroll copy write outside the scroll sequence");

endmodule

// ----- tb/sv/tcw_console_checker.sv -----
// Checker for the text console character writer: predicts each result and compares it.
module tcw_console_checker
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STEP = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcw_in_if           in_mon,
  tcw_out_if          out_mon,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CELLS = COLUMNS * ROWS;

  logic [15:0] screen [CELLS];
  int unsigned cursor_pos = 0;
  out_item_t   predicted_updates [$];
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  // Applies one character to the screen copy and returns the update it causes.
  function automatic out_item_t advance_console(in_item_t it);
    out_item_t   r;
    int unsigned pos;
    int unsigned i;
    r   = '0;
    pos = cursor_pos;
    if (pos >= CELLS) pos = CELLS - 1;
    if (it.char_code >= CHAR_PRINT_LO && it.char_code <= CHAR_PRINT_HI) begin
      r.cell_written = 1'b1;
      r.cell_address = POS_W'(pos);
      r.cell_value   = {it.attribute, it.char_code};
      screen[pos]    = {it.attribute, it.char_code};
      pos            = pos + 1;
    end else if (it.char_code == CHAR_NEWLINE) begin
      pos = (pos / COLUMNS + 1) * COLUMNS;
    end else if (it.char_code == CHAR_TAB) begin
      pos = pos + TAB_STEP;
    end
    // The cell written above is already in place, so it moves up with the rest.
    if (pos >= CELLS) begin
      for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
      r.scrolled = 1'b1;
      pos        = pos - COLUMNS;
      if (pos >= CELLS) pos = CELLS - 1;
    end
    cursor_pos        = pos;
    r.cursor_position = POS_W'(pos);
    r.last_of_write   = it.end_of_buffer;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t   want;
    out_item_t   got;
    logic        bad;
    int unsigned i;
    if (!rst_ni) begin
      cursor_pos = 0;
      for (i = 0; i < CELLS; i++) screen[i] = '0;
      predicted_updates.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (predicted_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result cursor %0d addr %0d value %h", $realtime,
                     got.cursor_position, got.cell_address, got.cell_value);
        end else begin
          want = predicted_updates.pop_front();
          bad  = (got.cursor_position !== want.cursor_position) ||
                 (got.cell_written    !== want.cell_written)    ||
                 (got.cell_address    !== want.cell_address)    ||
                 (got.cell_value      !== want.cell_value)      ||
                 (got.scrolled        !== want.scrolled)        ||
                 (got.last_of_write   !== want.last_of_write);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch (expected/actual) cursor %0d/%0d written %0b/%0b",
                     $realtime, want.cursor_position, got.cursor_position,
                     want.cell_written, got.cell_written);
              $display(" addr %0d/%0d value %h/%h scrolled %0b/%0b last %0b/%0b",
                       want.cell_address, got.cell_address, want.cell_value,
                       got.cell_value, want.scrolled, got.scrolled,
                       want.last_of_write, got.last_of_write);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predicted_updates.push_back(advance_console(in_mon.data));
    end
    pending = predicted_updates.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the text console character writer: clock, reset, stimulus and verdict.
module tb
  import tcw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMNS          = 80;
  localparam int unsigned ROWS             = 25;
  localparam int unsigned TAB_STEP         = 4;
  localparam int unsigned RANDOM_ITEMS     = 1250;
  localparam int unsigned CALM_TAIL        = 150;
  localparam int unsigned LONG_HOLD_AT     = 400;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  // A scroll keeps the block busy after its result has come out.
  localparam int unsigned TAIL_CYCLES      = COLUMNS * ROWS + 100;
  localparam int unsigned CYCLE_LIMIT      = 8_000_000;

  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_VTAB      = 8'h0b;
  localparam logic [7:0] CHAR_RETURN    = 8'h0d;
  localparam logic [7:0] CHAR_DELETE    = 8'h7f;

  logic clk_i;
  logic rst_ni;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned sent_cnt      = 0;
  int unsigned useful_sent   = 0;
  int unsigned send_idle_pct = 0;
  bit          calm          = 1'b0;
  int unsigned cycle_cnt;

  text_console_char_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STEP(TAB_STEP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  tcw_console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STEP(TAB_STEP)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("text_console_char_writer regression: fail");
    $finish;
  end

  // Offers one character, with an optional idle burst before it.
  task automatic send_char(input logic [7:0] ch, input logic [7:0] attr, input logic eob);
    in_item_t    it;
    in_item_t    junk;
    int unsigned gap;
    it.char_code     = ch;
    it.attribute     = attr;
    it.end_of_buffer = eob;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk_i);
      junk         = in_item_t'($urandom);
      in_ch.valid <= 1'b0;
      in_ch.data  <= junk;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_cnt++;
    if ((ch >= CHAR_PRINT_LO && ch <= CHAR_PRINT_HI) || ch == CHAR_TAB || ch == CHAR_NEWLINE)
      useful_sent++;
  endtask

  // Stops offering and waits until every predicted update has come out.
  task automatic drain_updates();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] ignored_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CHAR_PRINT_LO && c <= CHAR_PRINT_HI) || c == CHAR_TAB || c == CHAR_NEWLINE);
    return c;
  endfunction

  // Output side: random stall bursts, one long hold-off, none near the end.
  initial begin : sink_side
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned rate_left;
    bit          long_hold_done;
    hold_left      = 0;
    stall_pct      = 0;
    rate_left      = 0;
    long_hold_done = 1'b0;
    out_ch.ready   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rate_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          2:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
        rate_left = $urandom_range(50, 300);
      end else begin
        rate_left--;
      end
      if (!long_hold_done && sent_cnt >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(1, 15);
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : source_side
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    int unsigned r;
    logic [7:0]  attr;
    logic [7:0]  ch;
    logic [7:0]  a;
    logic        eob;
    bit          paused_once;
    paused_once = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, every kind of byte, and bytes just outside the printable range.
    send_char(8'h41, 8'h07, 1'b0);
    send_char(CHAR_PRINT_LO, 8'h00, 1'b0);
    send_char(CHAR_PRINT_HI, 8'hff, 1'b1);
    send_char(CHAR_PRINT_LO - 8'd1, 8'h1e, 1'b0);
    send_char(CHAR_DELETE, 8'h70, 1'b0);
    send_char(8'h00, 8'haa, 1'b0);
    send_char(8'hff, 8'h55, 1'b1);
    send_char(CHAR_TAB, 8'h55, 1'b0);
    send_char(CHAR_BACKSPACE, 8'h0f, 1'b0);
    send_char(CHAR_RETURN, 8'hf0, 1'b0);
    send_char(CHAR_NEWLINE, 8'h00, 1'b1);
    send_char(CHAR_VTAB, 8'hff, 1'b0);
    send_char(CHAR_TAB, 8'hff, 1'b0);
    send_char(8'h7a, 8'h81, 1'b1);
    send_char(8'h80, 8'h7e, 1'b1);
    send_char(CHAR_NEWLINE, 8'hff, 1'b0);
    drain_updates();
    useful_sent = 0;

    while (useful_sent < RANDOM_ITEMS) begin
      if (!paused_once && useful_sent >= RANDOM_ITEMS / 2) begin
        drain_updates();
        paused_once = 1'b1;
      end
      calm = (useful_sent + CALM_TAIL >= RANDOM_ITEMS);
      case ($urandom_range(0, 3))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 5;
        2:       send_idle_pct = 20;
        default: send_idle_pct = 50;
      endcase
      kind = $urandom_range(0, 9);
      attr = 8'($urandom_range(0, 255));
      case (kind)
        6, 7:    len = $urandom_range(76, 84);
        8:       len = $urandom_range(1, 20);
        9:       len = $urandom_range(1, 12);
        default: len = $urandom_range(1, 40);
      endcase
      for (k = 0; k < len; k++) begin
        r   = $urandom_range(0, 99);
        a   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : attr;
        eob = (k == len - 1);
        case (kind)
          // Long lines often run across a row end and close with a newline.
          6, 7: ch = (k == len - 1) ? CHAR_NEWLINE
                                    : 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
          8:    ch = (r < 50) ? CHAR_TAB : 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
          9: begin
            ch  = 8'($urandom_range(0, 255));
            a   = 8'($urandom_range(0, 255));
            eob = 1'($urandom_range(0, 1));
          end
          default: begin
            if (r < 84)      ch = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
            else if (r < 91) ch = CHAR_NEWLINE;
            else if (r < 96) ch = CHAR_TAB;
            else             ch = ignored_byte();
          end
        endcase
        send_char(ch, a, eob);
      end
    end

    drain_updates();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("text_console_char_writer regression: pass");
    end else begin
      $display("text_console_char_writer regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tcw_pkg.sv
design/tcw_ifs.sv
design/text_console_char_writer.sv
tb/sv/tcw_console_checker.sv
tb/sv/tb.sv
